/* rtl/kmp_substring_matcher_macros.svh */
// assertion macros for the kmp substring matcher
// expects clk and rst_n in the scope where a macro is used
`ifndef KMP_SUBSTRING_MATCHER_MACROS_SVH
`define KMP_SUBSTRING_MATCHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define KMP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/kmp_pkg.sv */
// shared types and constants for the kmp substring matcher
// no dependencies
`default_nettype none

package kmp_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int BYTE_W          = 8;

    // input queue between front and engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        KIND_PATTERN = 1'b0,
        KIND_TEXT    = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } kmp_item_t;

    typedef struct packed
    {
        logic found;
        logic text_done;
        logic overflow;
    } kmp_result_t;

endpackage

`default_nettype wire

/* rtl/kmp_front.sv */
// front end: accepts stream items, classifies them and queues them
// depends on kmp_pkg
`default_nettype none

module kmp_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [kmp_pkg::BYTE_W-1:0] s_axis_tdata,
    input  wire logic                       s_axis_tuser,
    input  wire logic                       s_axis_tlast,
    output logic                            q_valid,
    output kmp_pkg::kmp_item_t              q_item,
    input  wire logic                       q_pop
);
    import kmp_pkg::*;

    kmp_item_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                    push;
    kmp_item_t               in_item;

    // classify: tuser selects pattern or text
    always_comb
    begin
        in_item.kind = s_axis_tuser ? KIND_TEXT : KIND_PATTERN;
        in_item.data = s_axis_tdata;
        in_item.last = s_axis_tlast;
    end

    assign s_axis_tready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign q_item        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/kmp_engine.sv */
// back end: pattern store, failure table and the kmp scan sequencer
// depends on kmp_pkg
`default_nettype none

module kmp_engine
#(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire kmp_pkg::kmp_item_t   q_item,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output kmp_pkg::kmp_result_t      out_result
);
    import kmp_pkg::*;

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } state_t;

    logic [BYTE_W-1:0] pat_mem  [MAX_PATTERN];
    logic [IW-1:0]     fail_mem [MAX_PATTERN];
    logic [BYTE_W-1:0] rd_pat;
    logic [IW-1:0]     rd_fail;

    state_t            state_reg, state_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [IW-1:0]     build_reg, build_next;
    logic [LW-1:0]     match_reg, match_next;
    logic              found_reg, found_next;
    logic              ovf_reg, ovf_next;
    logic              complete_reg, complete_next;
    logic              out_valid_reg, out_valid_next;
    kmp_result_t       out_reg, out_next;
    logic [IW-1:0]     k_reg, k_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              text_reg, text_next;

    logic              slot_free;
    logic              hit;
    logic [IW-1:0]     fb;
    logic [LW-1:0]     t_val;
    logic              full_match;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_pat;
    logic [IW-1:0]     wr_fail;
    logic [IW-1:0]     rd_fail_addr;
    logic [LW-1:0]     len_eff;
    logic [IW-1:0]     build_eff;
    logic              ovf_eff;

    assign slot_free  = !out_valid_reg || out_ready;
    assign q_pop      = (state_reg == ST_IDLE) && q_valid && slot_free;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // one fallback step per cycle
    assign hit        = (byte_reg == rd_pat);
    assign fb         = (rd_fail < k_reg) ? rd_fail : '0;
    assign t_val      = LW'(k_reg) + LW'(hit);
    assign full_match = (t_val >= len_reg);

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        build_next     = build_reg;
        match_next     = match_reg;
        found_next     = found_reg;
        ovf_next       = ovf_reg;
        complete_next  = complete_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        k_next         = k_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        text_next      = text_reg;
        wr_en          = 1'b0;
        wr_addr        = len_reg[IW-1:0];
        wr_pat         = byte_reg;
        wr_fail        = t_val[IW-1:0];

        // a pattern byte after a complete pattern starts over
        len_eff   = complete_reg ? '0 : len_reg;
        build_eff = complete_reg ? '0 : build_reg;
        ovf_eff   = complete_reg ? 1'b0 : ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    byte_next = q_item.data;
                    last_next = q_item.last;
                    text_next = (q_item.kind == KIND_TEXT);
                    if (q_item.kind == KIND_PATTERN)
                    begin
                        len_next      = len_eff;
                        build_next    = build_eff;
                        ovf_next      = ovf_eff;
                        complete_next = 1'b0;
                        if (complete_reg)
                        begin
                            match_next = '0;
                            found_next = 1'b0;
                        end
                        if (len_eff == '0)
                        begin
                            // first byte: table entry is zero
                            wr_en          = 1'b1;
                            wr_addr        = '0;
                            wr_pat         = q_item.data;
                            wr_fail        = '0;
                            build_next     = '0;
                            len_next       = LW'(1);
                            complete_next  = q_item.last;
                            out_next       = '{found: 1'b0, text_done: 1'b0, overflow: ovf_eff};
                            out_valid_next = 1'b1;
                        end
                        else if (len_eff < MAX_LEN)
                        begin
                            k_next     = build_eff;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            // past capacity: drop the byte
                            ovf_next       = 1'b1;
                            complete_next  = q_item.last;
                            out_next       = '{found: 1'b0, text_done: 1'b0, overflow: 1'b1};
                            out_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (found_reg || !complete_reg || ovf_reg || (len_reg == '0))
                        begin
                            out_next       = '{found: found_reg, text_done: q_item.last,
                                               overflow: ovf_reg};
                            out_valid_next = 1'b1;
                            if (q_item.last)
                            begin
                                match_next = '0;
                                found_next = 1'b0;
                            end
                        end
                        else
                        begin
                            k_next     = match_reg[IW-1:0];
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if ((k_reg != '0) && !hit)
                begin
                    k_next = fb;
                end
                else
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (!text_reg)
                    begin
                        wr_en         = 1'b1;
                        build_next    = t_val[IW-1:0];
                        len_next      = len_reg + 1'b1;
                        complete_next = last_reg;
                        out_next      = '{found: 1'b0, text_done: 1'b0, overflow: ovf_reg};
                    end
                    else
                    begin
                        match_next = full_match ? len_reg : t_val;
                        found_next = full_match;
                        out_next   = '{found: full_match, text_done: last_reg,
                                       overflow: ovf_reg};
                        if (last_reg)
                        begin
                            match_next = '0;
                            found_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_fail_addr = k_next - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            build_reg     <= '0;
            match_reg     <= '0;
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            complete_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            k_reg         <= '0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            text_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            build_reg     <= build_next;
            match_reg     <= match_next;
            found_reg     <= found_next;
            ovf_reg       <= ovf_next;
            complete_reg  <= complete_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            k_reg         <= k_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            text_reg      <= text_next;
        end
    end

    // pattern store and failure table, read registered at the next prefix
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pat_mem[wr_addr]  <= wr_pat;
            fail_mem[wr_addr] <= wr_fail;
        end
        rd_pat  <= pat_mem[k_next];
        rd_fail <= fail_mem[rd_fail_addr];
    end

endmodule

`default_nettype wire

/* rtl/kmp_substring_matcher.sv */
// streaming kmp substring matcher: top level
// depends on kmp_pkg, kmp_front, kmp_engine and kmp_substring_matcher_macros.svh
//
// usage
//   slave side takes one byte per item: tuser low loads a pattern byte, tuser high
//   scans a text byte; tlast marks the final byte of the pattern or of the text
//   every item gives exactly one result on the master side: tdata bit 0 is found
//   (sticky within a text), bit 1 is pattern overflow, tlast is text done
//   a pattern byte after a finished pattern starts a new pattern
// queueing and pacing
//   items enter a two-entry queue, the engine takes one item at a time
//   pattern byte zero, dropped overflow bytes and text bytes that cannot match
//   are answered from the idle state, the result registered as the engine takes them
//   other bytes go on to a scan state that walks the failure-table fallbacks
//   for that byte: one memory read per fallback step sets the pace;
//   over a text, fallbacks never outnumber advances
// reset and stalls
//   reset clears the queue, the pattern length and all match state; pattern
//   store and failure table keep stale data and are only read below the length
//   a stalled result holds in the output register while the queue keeps
//   filling; tready drops only once the queue is full
`default_nettype none

`include "kmp_substring_matcher_macros.svh"

module kmp_substring_matcher
#(
    parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [kmp_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic                       s_axis_tuser,   // [0] mode
    input  wire logic                       s_axis_tlast,   // last_flag
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [0] found, [1] pattern_overflow
    output logic                            m_axis_tlast    // text_done
);
    import kmp_pkg::*;

    logic        q_valid;
    kmp_item_t   q_item;
    logic        q_pop;
    kmp_result_t result;
    logic        out_stall;
    logic        out_hit;

    // front: classify and queue incoming items
    kmp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // back: table build and text scan, result register
    kmp_engine
    #(
        .MAX_PATTERN (MAX_PATTERN)
    )
    u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {6'b0, result.overflow, result.found};
    assign m_axis_tlast = result.text_done;

    // result waiting on the receiver, and a result that reports a match
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_hit   = m_axis_tvalid && m_axis_tdata[0];

    // engine never pulls from an empty queue
    `KMP_ASSERT_IMPLY(a_pop_nonempty, q_pop, q_valid, "engine popped an empty queue")
    // engine holds off while a result is stalled
    `KMP_ASSERT_IMPLY(a_stall_no_pop, out_stall, !q_pop, "pop during output stall")
    // an overflowed pattern can never report a match
    `KMP_ASSERT_IMPLY(a_found_no_ovf, out_hit, !m_axis_tdata[1], "found with overflowed pattern")

endmodule

`default_nettype wire

/* tb/sv/kmp_substring_matcher_tb.sv */
// self-checking testbench for the streaming kmp substring matcher
// depends on kmp_pkg and the kmp_substring_matcher rtl; a class-based
// verdict board predicts every result and compares it with the output stream
`timescale 1ns / 100ps

module kmp_substring_matcher_tb;

    localparam int PAT_CAP       = kmp_pkg::MAX_PATTERN_DEF;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int STALL_LIMIT   = 4000;   // cycles with no item moving on either side
    localparam int TAIL_CYCLES   = 80;     // longest fallback chain plus output slack
    localparam int HOLD_CYCLES   = 250;    // long receiver hold-off
    localparam int HOLD_AFTER    = 300;    // results seen before the hold-off starts

    // predicts the match verdict for every accepted item and checks the results
    class kmp_verdict_board;
        logic [7:0]  pat_bytes [PAT_CAP];
        logic [5:0]  fail_links [PAT_CAP];
        logic [5:0]  pat_len;
        logic [5:0]  build_len;
        logic [5:0]  match_len;
        bit          hit;
        bit          pat_too_long;
        bit          pat_ready;
        kmp_pkg::kmp_result_t verdicts_due [$];
        int unsigned mismatches;
        int unsigned pattern_items;
        int unsigned text_items;
        int unsigned texts_closed;
        int unsigned texts_hit;
        int unsigned overflow_verdicts;

        function new();
            foreach (pat_bytes[i])
            begin
                pat_bytes[i]  = 8'h00;
                fail_links[i] = 6'd0;
            end
            pat_len      = 6'd0;
            build_len    = 6'd0;
            match_len    = 6'd0;
            hit          = 1'b0;
            pat_too_long = 1'b0;
            pat_ready    = 1'b0;
        endfunction

        function logic [7:0] pat_byte_at(logic [5:0] k);
            return (k < PAT_CAP) ? pat_bytes[int'(k)] : 8'h00;
        endfunction

        // one fallback step from a nonzero prefix length
        function logic [5:0] step_back(logic [5:0] k);
            logic [5:0] i;
            logic [5:0] v;
            i = k - 6'd1;
            v = (i < PAT_CAP) ? fail_links[int'(i)] : 6'd0;
            return (v < k) ? v : 6'd0;
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction

        function void note_item(kmp_pkg::kmp_item_t it);
            kmp_pkg::kmp_result_t r;
            logic [5:0] t;
            if (it.kind == kmp_pkg::KIND_PATTERN)
            begin
                pattern_items++;
                // a pattern byte after a finished pattern starts over
                if (pat_ready)
                begin
                    pat_len      = 6'd0;
                    build_len    = 6'd0;
                    pat_too_long = 1'b0;
                    pat_ready    = 1'b0;
                    match_len    = 6'd0;
                    hit          = 1'b0;
                end
                if (pat_len < PAT_CAP)
                begin
                    pat_bytes[int'(pat_len)] = it.data;
                    if (pat_len == 6'd0)
                    begin
                        fail_links[0] = 6'd0;
                        build_len     = 6'd0;
                    end
                    else
                    begin
                        t = build_len;
                        while (t != 6'd0 && it.data != pat_byte_at(t))
                            t = step_back(t);
                        if (it.data == pat_byte_at(t))
                            t = t + 6'd1;
                        fail_links[int'(pat_len)] = t;
                        build_len = t;
                    end
                    pat_len = pat_len + 6'd1;
                end
                else
                    pat_too_long = 1'b1;
                if (it.last)
                    pat_ready = 1'b1;
                r.found     = 1'b0;
                r.text_done = 1'b0;
                r.overflow  = pat_too_long;
            end
            else
            begin
                text_items++;
                // no usable pattern or already found: the byte changes nothing
                if (!hit && pat_ready && !pat_too_long && pat_len != 6'd0)
                begin
                    t = match_len;
                    while (t != 6'd0 && it.data != pat_byte_at(t))
                        t = step_back(t);
                    if (it.data == pat_byte_at(t))
                        t = t + 6'd1;
                    if (t >= pat_len)
                    begin
                        t   = pat_len;
                        hit = 1'b1;
                    end
                    match_len = t;
                end
                r.found     = hit;
                r.text_done = it.last;
                r.overflow  = pat_too_long;
                if (it.last)
                begin
                    texts_closed++;
                    if (hit)
                        texts_hit++;
                    match_len = 6'd0;
                    hit       = 1'b0;
                end
            end
            if (r.overflow)
                overflow_verdicts++;
            verdicts_due.push_back(r);
        endfunction

        function void compare_bit(string field, logic want, logic got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0b actual %0b", $time, field, want, got);
            end
        endfunction

        function void check_verdict(kmp_pkg::kmp_result_t got);
            kmp_pkg::kmp_result_t want;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none actual %b", $time, got);
                return;
            end
            want = verdicts_due.pop_front();
            compare_bit("found", want.found, got.found);
            compare_bit("text_done", want.text_done, got.text_done);
            compare_bit("pattern_overflow", want.overflow, got.overflow);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] data_byte
    logic       s_axis_tuser;    // [0] mode
    logic       s_axis_tlast;    // last_flag
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [0] found, [1] pattern_overflow
    logic       m_axis_tlast;    // text_done

    kmp_verdict_board     board;
    kmp_pkg::kmp_item_t   stim_items [$];
    int unsigned          results_seen;
    int unsigned          quiet_cycles;

    always #4 clk = ~clk;

    kmp_substring_matcher u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task automatic add_item(kmp_pkg::kind_t kind, logic [7:0] data, logic last);
        kmp_pkg::kmp_item_t it;
        it.kind = kind;
        it.data = data;
        it.last = last;
        stim_items.push_back(it);
    endtask

    // a pattern over a tiny random alphabet, then a few texts that often
    // contain it, so prefixes grow and fallbacks get exercised
    task automatic add_matching_run();
        logic [7:0] alphabet [3];
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        int         asize;
        int         plen;
        int         tlen;
        int         at;
        foreach (alphabet[i])
            alphabet[i] = 8'($urandom_range(255));
        asize = $urandom_range(3, 2);
        if ($urandom_range(9) == 0)
            plen = $urandom_range(1) ? PAT_CAP : $urandom_range(PAT_CAP - 1, 9);
        else
            plen = $urandom_range(6, 1);
        for (int i = 0; i < plen; i++)
            pat.push_back(alphabet[$urandom_range(asize - 1)]);
        for (int i = 0; i < plen; i++)
            add_item(kmp_pkg::KIND_PATTERN, pat[i], i == plen - 1);
        repeat ($urandom_range(4, 1))
        begin
            tlen = $urandom_range(20, 1);
            txt.delete();
            for (int i = 0; i < tlen; i++)
                txt.push_back(alphabet[$urandom_range(asize - 1)]);
            // plant the pattern in about half of the texts
            if ($urandom_range(1) && plen <= tlen)
            begin
                at = $urandom_range(tlen - plen);
                for (int i = 0; i < plen; i++)
                    txt[at + i] = pat[i];
            end
            for (int i = 0; i < tlen; i++)
                add_item(kmp_pkg::KIND_TEXT, txt[i], i == tlen - 1);
        end
    endtask

    // pattern longer than the store, then a text that must never match
    task automatic add_overflow_run();
        int plen;
        int tlen;
        plen = $urandom_range(PAT_CAP + 8, PAT_CAP + 1);
        for (int i = 0; i < plen; i++)
            add_item(kmp_pkg::KIND_PATTERN, 8'($urandom_range(255)), i == plen - 1);
        tlen = $urandom_range(8, 1);
        for (int i = 0; i < tlen; i++)
            add_item(kmp_pkg::KIND_TEXT, 8'($urandom_range(1)), i == tlen - 1);
    endtask

    // fully random items: interleaved modes, stray last flags
    task automatic add_noise();
        repeat ($urandom_range(6, 1))
            add_item(kmp_pkg::kind_t'($urandom_range(1)), 8'($urandom_range(255)),
                     $urandom_range(3) == 0);
    endtask

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------

    // sender: random idles except in a burst window; tvalid stays high
    // across back-to-back items
    task automatic send_all();
        int unsigned n;
        n = 0;
        foreach (stim_items[k])
        begin
            if (n < 500 || n >= 700)
            begin
                while ($urandom_range(99) < 21)
                begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                end
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stim_items[k].data;
            s_axis_tuser  <= stim_items[k].kind;
            s_axis_tlast  <= stim_items[k].last;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            n++;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // receiver: random stalls, a stall-free stretch alongside the sender's
    // burst window and one long hold-off that lets the input queue fill
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
            end
            if (results_seen >= 500 && results_seen < 700)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 21);
        end
    end

    // ---------------------------------------------------------------
    // monitor and watchdog
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        kmp_pkg::kmp_item_t   it;
        kmp_pkg::kmp_result_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.kind = kmp_pkg::kind_t'(s_axis_tuser);
                it.data = s_axis_tdata;
                it.last = s_axis_tlast;
                board.note_item(it);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.found     = m_axis_tdata[0];
                got.overflow  = m_axis_tdata[1];
                got.text_done = m_axis_tlast;
                board.check_verdict(got);
                results_seen++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        board         = new();
        results_seen  = 0;
        quiet_cycles  = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= kmp_pkg::KIND_PATTERN;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;

        // directed: text with no pattern loaded at all
        add_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'hFF, 1'b1);
        // one-byte pattern at the top code, found stays set after the hit
        add_item(kmp_pkg::KIND_PATTERN, 8'hFF, 1'b1);
        add_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'hFF, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b1);
        // new pattern "aba" replaces the finished one
        add_item(kmp_pkg::KIND_PATTERN, 8'h61, 1'b0);
        add_item(kmp_pkg::KIND_PATTERN, 8'h62, 1'b0);
        add_item(kmp_pkg::KIND_PATTERN, 8'h61, 1'b1);
        // "aabab": fallback on the second a, match, then an ignored byte
        add_item(kmp_pkg::KIND_TEXT, 8'h61, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'h61, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'h62, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'h61, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'h62, 1'b1);
        // text arriving while a pattern is half loaded never matches
        add_item(kmp_pkg::KIND_PATTERN, 8'h00, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b1);
        add_item(kmp_pkg::KIND_PATTERN, 8'h00, 1'b1);
        add_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'h00, 1'b1);
        // a text that misses entirely
        add_item(kmp_pkg::KIND_TEXT, 8'h80, 1'b0);
        add_item(kmp_pkg::KIND_TEXT, 8'h7F, 1'b1);

        // random: an overflowed pattern first, then mostly well-formed runs
        add_overflow_run();
        while (stim_items.size() < RANDOM_ITEMS + 21)
        begin
            case ($urandom_range(99)) inside
                [0:71]:  add_matching_run();
                [72:79]: add_overflow_run();
                default: add_noise();
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_all();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d pattern and %0d text items, %0d texts closed, %0d with a match",
                 board.pattern_items, board.text_items, board.texts_closed, board.texts_hit);
        $display("%0d results carried the overflow flag, %0d mismatches",
                 board.overflow_verdicts, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
